>>> rtl/core/ihx_pkg.sv
// Shared types, codes and constants of the Intel HEX record parser.
`default_nettype none

package ihx_pkg;

  localparam int unsigned MaxDataBytesDef = 16;
  localparam int unsigned LineBufferDef   = 256;
  localparam int unsigned MinLine         = 11;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam logic [7:0] RecData   = 8'h00;
  localparam logic [7:0] RecEof    = 8'h01;
  localparam logic [7:0] RecExtLin = 8'h04;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DRAIN,
    ST_AFTER_EOF,
    ST_HALT
  } ihx_state_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EOF   = 2'd1,
    KIND_ERROR = 2'd2
  } ihx_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_OVERLONG     = 4'd1,
    ERR_NO_COLON     = 4'd2,
    ERR_TOO_SHORT    = 4'd3,
    ERR_NON_HEX      = 4'd4,
    ERR_LEN_MISMATCH = 4'd5,
    ERR_CHECKSUM     = 4'd6,
    ERR_ZERO_LEN     = 4'd7,
    ERR_DATA_LONG    = 4'd8,
    ERR_EOF_LEN      = 4'd9,
    ERR_ADDR_LEN     = 4'd10,
    ERR_BAD_TYPE     = 4'd11,
    ERR_AFTER_EOF    = 4'd12
  } ihx_err_e;

  typedef struct packed {
    logic      char_en;
    logic      line_clr;
    logic      upper_ld;
    logic      drain_start;
    logic      drain_step;
    logic      res_ld;
    ihx_kind_e res_kind;
    ihx_err_e  res_err;
  } ihx_cmd_t;

  typedef struct packed {
    logic     is_newline;
    logic     overlong;
    ihx_err_e line_err;
    logic     rec_data;
    logic     rec_eof;
    logic     drain_last;
    logic     out_busy;
  } ihx_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ihx_datapath.sv
// Datapath: line decoding, record fields, data byte store and result register.
`default_nettype none

module ihx_datapath #(
  parameter int unsigned MAX_DATA_BYTES = ihx_pkg::MaxDataBytesDef,
  parameter int unsigned LINE_BUFFER    = ihx_pkg::LineBufferDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       char_code_i,
  input  wire ihx_pkg::ihx_cmd_t cmd_i,
  output ihx_pkg::ihx_stat_t    stat_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            kind_o,
  output logic [31:0]           byte_address_o,
  output logic [7:0]            data_byte_o,
  output logic [3:0]            error_code_o,
  output logic                  last_o
);
  import ihx_pkg::*;

  localparam int unsigned StoreDepth = (MAX_DATA_BYTES < 2) ? 2 : MAX_DATA_BYTES;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(LINE_BUFFER);
  localparam int unsigned CmpW       = (CntW > 8) ? CntW + 1 : 10;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [4:0]      nib_q, nib_d;
  logic [8:0]      pair_q, pair_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      len_q, len_d;
  logic [15:0]     ofs_q, ofs_d;
  logic [7:0]      type_q, type_d;
  logic            colon_q, colon_d;
  logic            nonhex_q, nonhex_d;
  logic            cr_q, cr_d;
  logic [15:0]     upper_q;
  logic [IdxW-1:0] idx_q;
  logic [7:0]      store_q [StoreDepth];

  logic            out_valid_q;
  ihx_kind_e       kind_q;
  logic [31:0]     addr_q;
  logic [7:0]      data_q;
  ihx_err_e        err_q;
  logic            last_q;

  logic [4:0]      hx;
  logic            byte_en;
  logic [7:0]      byte_val;
  logic [8:0]      data_idx;
  logic            store_we;
  logic [CntW-1:0] line_len;
  logic [CmpW-1:0] len_lhs, len_rhs;
  ihx_err_e        line_err;
  logic            drain_last;

  assign hx       = hex_decode(char_code_i);
  assign byte_val = {nib_q[3:0], hx[3:0]};
  assign data_idx = pair_q - 9'd4;
  assign store_we = byte_en && (pair_q >= 9'd4) && (data_idx < 9'(StoreDepth));

  always_comb begin
    cnt_d    = cnt_q;
    nib_d    = nib_q;
    pair_d   = pair_q;
    sum_d    = sum_q;
    len_d    = len_q;
    ofs_d    = ofs_q;
    type_d   = type_q;
    colon_d  = colon_q;
    nonhex_d = nonhex_q;
    cr_d     = cr_q;
    byte_en  = 1'b0;
    if (cmd_i.line_clr) begin
      cnt_d    = '0;
      nib_d    = '0;
      pair_d   = '0;
      sum_d    = '0;
      colon_d  = 1'b0;
      nonhex_d = 1'b0;
      cr_d     = 1'b0;
    end else if (cmd_i.char_en) begin
      // a carriage return not followed by the newline is a bad character
      if (cr_q) begin
        cr_d     = 1'b0;
        nonhex_d = 1'b1;
      end
      if (cnt_q == '0) begin
        if (char_code_i == CharColon) begin
          colon_d = 1'b1;
        end
      end else if (char_code_i == CharCr) begin
        cr_d = 1'b1;
      end else if (!(nonhex_q || cr_q)) begin
        if (!hx[4]) begin
          nonhex_d = 1'b1;
        end else if (nib_q[4]) begin
          byte_en = 1'b1;
          nib_d   = '0;
        end else begin
          nib_d = hx;
        end
      end
      cnt_d = cnt_q + CntW'(1);
    end
    if (byte_en) begin
      sum_d = sum_q + byte_val;
      case (pair_q)
        9'd0:    len_d = byte_val;
        9'd1:    ofs_d = {byte_val, 8'h00};
        9'd2:    ofs_d = {ofs_q[15:8], byte_val};
        9'd3:    type_d = byte_val;
        default: ;
      endcase
      if (pair_q != 9'h1FF) begin
        pair_d = pair_q + 9'd1;
      end
    end
  end

  assign line_len = cnt_q - CntW'(cr_q);
  assign len_lhs  = CmpW'(line_len) - CmpW'(MinLine);
  assign len_rhs  = CmpW'({len_q, 1'b0});

  always_comb begin
    line_err = ERR_NONE;
    if (!colon_q) begin
      line_err = ERR_NO_COLON;
    end else if (CmpW'(line_len) < CmpW'(MinLine)) begin
      line_err = ERR_TOO_SHORT;
    end else if (nonhex_q) begin
      line_err = ERR_NON_HEX;
    end else if (len_lhs != len_rhs) begin
      line_err = ERR_LEN_MISMATCH;
    end else if (sum_q != 8'h00) begin
      line_err = ERR_CHECKSUM;
    end else if (type_q == RecData) begin
      if (len_q == 8'h00) begin
        line_err = ERR_ZERO_LEN;
      end else if (len_q > 8'(MAX_DATA_BYTES)) begin
        line_err = ERR_DATA_LONG;
      end
    end else if (type_q == RecEof) begin
      if (len_q != 8'h00) begin
        line_err = ERR_EOF_LEN;
      end
    end else if (type_q == RecExtLin) begin
      if (len_q != 8'h02) begin
        line_err = ERR_ADDR_LEN;
      end
    end else begin
      line_err = ERR_BAD_TYPE;
    end
  end

  assign drain_last = (9'(idx_q) + 9'd1) == 9'(len_q);

  assign stat_o.is_newline = (char_code_i == CharLf);
  assign stat_o.overlong   = (cnt_q >= CntW'(LINE_BUFFER - 2));
  assign stat_o.line_err   = line_err;
  assign stat_o.rec_data   = (type_q == RecData);
  assign stat_o.rec_eof    = (type_q == RecEof);
  assign stat_o.drain_last = drain_last;
  assign stat_o.out_busy   = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      nib_q    <= '0;
      pair_q   <= '0;
      sum_q    <= '0;
      len_q    <= '0;
      ofs_q    <= '0;
      type_q   <= '0;
      colon_q  <= 1'b0;
      nonhex_q <= 1'b0;
      cr_q     <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      nib_q    <= nib_d;
      pair_q   <= pair_d;
      sum_q    <= sum_d;
      len_q    <= len_d;
      ofs_q    <= ofs_d;
      type_q   <= type_d;
      colon_q  <= colon_d;
      nonhex_q <= nonhex_d;
      cr_q     <= cr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[data_idx[IdxW-1:0]] <= byte_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upper_ld) begin
        upper_q <= {store_q[0], store_q[1]};
      end
      if (cmd_i.drain_start) begin
        idx_q <= '0;
      end else if (cmd_i.drain_step) begin
        idx_q <= idx_q + IdxW'(1);
      end
      out_valid_q <= cmd_i.res_ld || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      kind_q <= cmd_i.res_kind;
      if (cmd_i.res_kind == KIND_DATA) begin
        addr_q <= {upper_q, ofs_q} + 32'(idx_q);
        data_q <= store_q[idx_q];
        err_q  <= ERR_NONE;
        last_q <= drain_last;
      end else begin
        addr_q <= '0;
        data_q <= '0;
        err_q  <= cmd_i.res_err;
        last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign byte_address_o = addr_q;
  assign data_byte_o    = data_q;
  assign error_code_o   = err_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

>>> rtl/core/ihx_ctrl.sv
// Controller: run state machine that sequences line checks, byte drain and halt.
`default_nettype none

module ihx_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ihx_pkg::ihx_stat_t stat_i,
  output ihx_pkg::ihx_cmd_t      cmd_o
);
  import ihx_pkg::*;

  ihx_state_e state_q, state_d;
  logic       in_acc;

  assign in_stall_o = stat_i.out_busy || (state_q == ST_DRAIN);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_kind = KIND_ERROR;
    cmd_o.res_err  = ERR_NONE;
    case (state_q)
      ST_COLLECT: begin
        if (in_acc) begin
          if (stat_i.is_newline) begin
            cmd_o.line_clr = 1'b1;
            if (stat_i.line_err != ERR_NONE) begin
              cmd_o.res_ld  = 1'b1;
              cmd_o.res_err = stat_i.line_err;
              state_d       = ST_HALT;
            end else if (stat_i.rec_data) begin
              cmd_o.drain_start = 1'b1;
              state_d           = ST_DRAIN;
            end else if (stat_i.rec_eof) begin
              cmd_o.res_ld   = 1'b1;
              cmd_o.res_kind = KIND_EOF;
              state_d        = ST_AFTER_EOF;
            end else begin
              cmd_o.upper_ld = 1'b1;
            end
          end else if (stat_i.overlong) begin
            cmd_o.line_clr = 1'b1;
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_err  = ERR_OVERLONG;
            state_d        = ST_HALT;
          end else begin
            cmd_o.char_en = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.drain_step = 1'b1;
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_kind   = KIND_DATA;
          if (stat_i.drain_last) begin
            state_d = ST_COLLECT;
          end
        end
      end
      ST_AFTER_EOF: begin
        if (in_acc) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_err = ERR_AFTER_EOF;
          state_d       = ST_HALT;
        end
      end
      ST_HALT: begin
      end
      default: begin
        state_d = ST_HALT;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/intel_hex_record_parser_top.sv
// Intel HEX record parser: one character word per cycle, emits data bytes, EOF or error.
// An error or EOF word is in the output register at the edge that takes its
// character; a record's first data byte lands there in the cycle after its newline.
// Throughput: one character per cycle when not stalled; a data record stalls input
// while the byte store drains to the output, one byte a cycle unless the output stalls.
// Reset clears the run state, line state and upper address; after an error the block
// takes and drops every character until reset.
`default_nettype none

module intel_hex_record_parser_top #(
  parameter int unsigned MAX_DATA_BYTES = ihx_pkg::MaxDataBytesDef,
  parameter int unsigned LINE_BUFFER    = ihx_pkg::LineBufferDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      byte_address_o,
  output logic [7:0]       data_byte_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);
  import ihx_pkg::*;

  ihx_cmd_t  cmd;
  ihx_stat_t stat;

  ihx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ihx_datapath #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .LINE_BUFFER    (LINE_BUFFER)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_code_i    (char_code_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .byte_address_o (byte_address_o),
    .data_byte_o    (data_byte_o),
    .error_code_o   (error_code_o),
    .last_o         (last_o)
  );

  a_data_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DATA) |-> (error_code_o == ERR_NONE))
    else $error("data word carries an error code");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ERROR) |-> last_o && (error_code_o != ERR_NONE))
    else $error("error word not final or without code");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (kind_o == KIND_ERROR) |=> !out_valid_o)
    else $error("word emitted after error");

  a_drain_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.drain_step |-> in_stall_o && !cmd.char_en)
    else $error("input taken during byte drain");

endmodule

`default_nettype wire
